FILE: rtl/core/hcte_pkg.sv
// Shared types, constants and symbol mapping functions for the mod-29 Hill encryptor.
package hcte_pkg;

	localparam int unsigned SYM_W     = 5;
	localparam int unsigned ACC_W     = 3;
	localparam int unsigned KEY_W     = 5;
	localparam int unsigned CFG_IDX_W = 4;

	localparam int unsigned MODULUS     = 29;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] LEAD_BYTE = 8'hC3;
	localparam logic [7:0] ASCII_MAX = 8'd127;

	localparam logic [SYM_W-1:0] PAD_SYMBOL = 5'd29;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [ACC_W-1:0] ACC_NONE       = 3'd0;
	localparam logic [ACC_W-1:0] ACC_TILDE      = 3'd1;
	localparam logic [ACC_W-1:0] ACC_ACUTE      = 3'd2;
	localparam logic [ACC_W-1:0] ACC_CIRCUMFLEX = 3'd3;
	localparam logic [ACC_W-1:0] ACC_GRAVE      = 3'd4;
	localparam logic [ACC_W-1:0] ACC_CEDILLA    = 3'd5;

	localparam logic [CFG_IDX_W-1:0] KEY_R0C0 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] KEY_R0C1 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] KEY_R1C0 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] KEY_R1C1 = 4'd3;

	localparam logic [KEY_W-1:0] KEY_R0C0_RST = 5'd1;
	localparam logic [KEY_W-1:0] KEY_R0C1_RST = 5'd0;
	localparam logic [KEY_W-1:0] KEY_R1C0_RST = 5'd0;
	localparam logic [KEY_W-1:0] KEY_R1C1_RST = 5'd1;

	typedef struct packed {
		logic       kind;
		logic [7:0] byte_value;
	} byte_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] cipher_symbol;
		logic [ACC_W-1:0] accent;
		logic             last_in_run;
		logic             end_of_text;
	} sym_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym0;
		logic [ACC_W-1:0] acc0;
		logic [SYM_W-1:0] sym1;
		logic [ACC_W-1:0] acc1;
		logic             eot;
	} pair_job_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [ACC_W-1:0] acc;
	} sym_acc_t;

	function automatic logic [SYM_W-1:0] ascii_symbol(input logic [7:0] b);
		logic [7:0] u;
		logic [SYM_W-1:0] s;
		u = b;
		s = '0;
		if (u >= 8'h61 && u <= 8'h7A) u = u - 8'd32;
		if (b == 8'h20 || b == 8'h23) s = 5'd29;
		else if (b == 8'h2E) s = 5'd27;
		else if (b == 8'h2C) s = 5'd28;
		else if (u >= 8'h41 && u <= 8'h5A) s = SYM_W'(u - 8'h40);
		return s;
	endfunction

	function automatic sym_acc_t accented_symbol(input logic [7:0] b);
		sym_acc_t r;
		r = '0;
		if (b >= 8'h80 && b <= 8'hBF) begin
			case (b & 8'hDF)
				8'h83: r = '{sym: 5'd1,  acc: ACC_TILDE};
				8'h95: r = '{sym: 5'd15, acc: ACC_TILDE};
				8'h81: r = '{sym: 5'd1,  acc: ACC_ACUTE};
				8'h89: r = '{sym: 5'd5,  acc: ACC_ACUTE};
				8'h8D: r = '{sym: 5'd9,  acc: ACC_ACUTE};
				8'h93: r = '{sym: 5'd15, acc: ACC_ACUTE};
				8'h9A: r = '{sym: 5'd21, acc: ACC_ACUTE};
				8'h82: r = '{sym: 5'd1,  acc: ACC_CIRCUMFLEX};
				8'h8A: r = '{sym: 5'd5,  acc: ACC_CIRCUMFLEX};
				8'h8E: r = '{sym: 5'd9,  acc: ACC_CIRCUMFLEX};
				8'h94: r = '{sym: 5'd15, acc: ACC_CIRCUMFLEX};
				8'h9B: r = '{sym: 5'd21, acc: ACC_CIRCUMFLEX};
				8'h80: r = '{sym: 5'd1,  acc: ACC_GRAVE};
				8'h88: r = '{sym: 5'd5,  acc: ACC_GRAVE};
				8'h8C: r = '{sym: 5'd9,  acc: ACC_GRAVE};
				8'h92: r = '{sym: 5'd15, acc: ACC_GRAVE};
				8'h99: r = '{sym: 5'd21, acc: ACC_GRAVE};
				8'h87: r = '{sym: 5'd3,  acc: ACC_CEDILLA};
				default: r = '0;
			endcase
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/hcte_front.sv
// Front end: byte classification, lead-byte joining and symbol pairing.
module hcte_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  hcte_pkg::byte_item_t byte_item,
	output logic                push_valid,
	input  logic                push_ready,
	output hcte_pkg::pair_job_t push_job
);
	import hcte_pkg::*;

	logic             lead_pending_q;
	logic             held_valid_q;
	logic [SYM_W-1:0] held_sym_q;
	logic [ACC_W-1:0] held_acc_q;

	logic             accept;
	logic             lead_set;
	sym_acc_t         cls;

	assign byte_ready = push_ready;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		cls      = '0;
		lead_set = 1'b0;
		if (lead_pending_q) begin
			cls = accented_symbol(byte_item.byte_value);
		end else if (byte_item.byte_value <= ASCII_MAX) begin
			cls.sym = ascii_symbol(byte_item.byte_value);
		end else begin
			lead_set = (byte_item.byte_value == LEAD_BYTE);
		end
	end

	always_comb begin
		push_job.sym0 = held_sym_q;
		push_job.acc0 = held_acc_q;
		if (byte_item.kind == KIND_END) begin
			push_job.sym1 = PAD_SYMBOL;
			push_job.acc1 = ACC_NONE;
			push_job.eot  = 1'b1;
			push_valid    = byte_valid && held_valid_q;
		end else begin
			push_job.sym1 = cls.sym;
			push_job.acc1 = cls.acc;
			push_job.eot  = 1'b0;
			push_valid    = byte_valid && held_valid_q && (cls.sym != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_pending_q <= 1'b0;
			held_valid_q   <= 1'b0;
		end else if (accept) begin
			if (byte_item.kind == KIND_END) begin
				lead_pending_q <= 1'b0;
				held_valid_q   <= 1'b0;
			end else begin
				lead_pending_q <= lead_set;
				if (cls.sym != '0) held_valid_q <= !held_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && byte_item.kind == KIND_TEXT && cls.sym != '0 && !held_valid_q) begin
			held_sym_q <= cls.sym;
			held_acc_q <= cls.acc;
		end
	end

`ifndef ASSERT_OFF
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && byte_item.kind == KIND_END) |=> (!held_valid_q && !lead_pending_q))
		else $error("end of text left front state set");
`endif

endmodule

FILE: rtl/core/hcte_fifo.sv
// Small pair-job queue between front end and back end.
module hcte_fifo #(
	parameter int unsigned DEPTH = hcte_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  hcte_pkg::pair_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output hcte_pkg::pair_job_t pop_job
);
	import hcte_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	pair_job_t        entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_job    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_job;
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
`endif

endmodule

FILE: rtl/core/hcte_back.sv
// Back end: key registers, mod-29 matrix product pipeline and symbol sequencer.
module hcte_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hcte_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hcte_pkg::KEY_W-1:0]        cfg_data,
	input  logic                              job_valid,
	output logic                              job_ready,
	input  hcte_pkg::pair_job_t               job,
	output logic                              sym_valid,
	input  logic                              sym_ready,
	output hcte_pkg::sym_item_t               sym_item
);
	import hcte_pkg::*;

	localparam int unsigned PROD_W      = 2 * SYM_W;
	localparam int unsigned SUM_W       = PROD_W + 1;
	localparam int unsigned RED_SHIFT   = 15;
	localparam int unsigned RED_MULT    = ((1 << RED_SHIFT) + MODULUS - 1) / MODULUS;
	localparam int unsigned RED_MULT_W  = $clog2(RED_MULT + 1);
	localparam int unsigned RED_PROD_W  = SUM_W + RED_MULT_W;
	localparam int unsigned QUOT_W      = 6;
	localparam logic [KEY_W-1:0]      MOD_K   = KEY_W'(MODULUS);
	localparam logic [RED_MULT_W-1:0] MULT_K  = RED_MULT_W'(RED_MULT);
	localparam logic [SUM_W-1:0]      MOD_SUM = SUM_W'(MODULUS);

	logic [KEY_W-1:0] k00_q, k01_q, k10_q, k11_q;
	logic [KEY_W-1:0] k00, k01, k10, k11;

	logic [SYM_W-1:0] x, y;
	logic             take1, take2, take3, done3;

	logic             v_s1;
	logic [SUM_W-1:0] sum0_s1, sum1_s1;
	logic [ACC_W-1:0] acc0_s1, acc1_s1;
	logic             eot_s1;

	logic              v_s2;
	logic [SUM_W-1:0]  sum0_s2, sum1_s2;
	logic [QUOT_W-1:0] q0_s2, q1_s2;
	logic [ACC_W-1:0]  acc0_s2, acc1_s2;
	logic              eot_s2;

	logic [RED_PROD_W-1:0] rp0, rp1;
	logic [SUM_W-1:0]      r0, r1;

	logic             v_s3;
	logic [SYM_W-1:0] c0_s3, c1_s3;
	logic [ACC_W-1:0] acc0_s3, acc1_s3;
	logic             eot_s3;
	logic             half_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k00_q <= KEY_R0C0_RST;
			k01_q <= KEY_R0C1_RST;
			k10_q <= KEY_R1C0_RST;
			k11_q <= KEY_R1C1_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				KEY_R0C0: k00_q <= cfg_data;
				KEY_R0C1: k01_q <= cfg_data;
				KEY_R1C0: k10_q <= cfg_data;
				KEY_R1C1: k11_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign k00 = (k00_q >= MOD_K) ? k00_q - MOD_K : k00_q;
	assign k01 = (k01_q >= MOD_K) ? k01_q - MOD_K : k01_q;
	assign k10 = (k10_q >= MOD_K) ? k10_q - MOD_K : k10_q;
	assign k11 = (k11_q >= MOD_K) ? k11_q - MOD_K : k11_q;

	assign x = job.sym0 - 1'b1;
	assign y = job.sym1 - 1'b1;

	assign done3     = v_s3 && sym_ready && half_q;
	assign take3     = v_s2 && (!v_s3 || done3);
	assign take2     = v_s1 && (!v_s2 || take3);
	assign take1     = job_valid && (!v_s1 || take2);
	assign job_ready = !v_s1 || take2;

	assign rp0 = sum0_s1 * MULT_K;
	assign rp1 = sum1_s1 * MULT_K;
	assign r0  = sum0_s2 - SUM_W'(q0_s2 * MOD_SUM);
	assign r1  = sum1_s2 - SUM_W'(q1_s2 * MOD_SUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			half_q <= 1'b0;
		end else begin
			if (take1)      v_s1 <= 1'b1;
			else if (take2) v_s1 <= 1'b0;
			if (take2)      v_s2 <= 1'b1;
			else if (take3) v_s2 <= 1'b0;
			if (take3)      v_s3 <= 1'b1;
			else if (done3) v_s3 <= 1'b0;
			if (sym_valid && sym_ready) half_q <= !half_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take1) begin
			sum0_s1 <= SUM_W'(k00 * x) + SUM_W'(k01 * y);
			sum1_s1 <= SUM_W'(k10 * x) + SUM_W'(k11 * y);
			acc0_s1 <= job.acc0;
			acc1_s1 <= job.acc1;
			eot_s1  <= job.eot;
		end
		if (take2) begin
			sum0_s2 <= sum0_s1;
			sum1_s2 <= sum1_s1;
			q0_s2   <= rp0[RED_SHIFT +: QUOT_W];
			q1_s2   <= rp1[RED_SHIFT +: QUOT_W];
			acc0_s2 <= acc0_s1;
			acc1_s2 <= acc1_s1;
			eot_s2  <= eot_s1;
		end
		if (take3) begin
			c0_s3   <= r0[SYM_W-1:0] + 1'b1;
			c1_s3   <= r1[SYM_W-1:0] + 1'b1;
			acc0_s3 <= acc0_s2;
			acc1_s3 <= acc1_s2;
			eot_s3  <= eot_s2;
		end
	end

	assign sym_valid              = v_s3;
	assign sym_item.cipher_symbol = half_q ? c1_s3 : c0_s3;
	assign sym_item.accent        = half_q ? acc1_s3 : acc0_s3;
	assign sym_item.last_in_run   = half_q;
	assign sym_item.end_of_text   = eot_s3;

`ifndef ASSERT_OFF
	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		sym_valid |-> (sym_item.cipher_symbol >= 5'd1 && sym_item.cipher_symbol <= 5'd29))
		else $error("cipher symbol out of range");
	a_reduce_exact: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (r0 < MOD_SUM && r1 < MOD_SUM))
		else $error("mod 29 reduction off");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && sym_ready && !half_q) |=> (sym_valid && sym_item.last_in_run))
		else $error("second symbol of pair missing");
`endif

endmodule

FILE: rtl/core/hill_cipher_mod29_text_encrypt_unit.sv
// Top level of the 2x2 mod-29 Hill cipher text encryptor.
// Accepts one UTF-8 byte (or an end-of-text marker) per cycle while the pair queue has room and
// emits cipher symbols one per cycle while sym_ready is high. Every two kept plaintext symbols
// produce a pair of results, issued one after the other, so the output port, at two results per
// pair, sets the sustained rate; with sym_ready held high, a byte stream of kept symbols runs
// at one byte per cycle without stalling. Bytes that are dropped, and a 0xC3 lead byte, are
// accepted and produce nothing. A pair is registered in the queue and then passes a three-stage
// product and reduction pipeline (s1 to s3) before its first symbol appears. Byte input stalls
// only while the pair queue is full. Key writes complete in the cycle they are presented; keys
// 29 to 31 act as their value mod 29. No clearing pass follows reset.
module hill_cipher_mod29_text_encrypt_unit #(
	parameter int unsigned QUEUE_DEPTH = hcte_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hcte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcte_pkg::KEY_W-1:0]     cfg_data,
	input  logic                           byte_valid,
	output logic                           byte_ready,
	input  hcte_pkg::byte_item_t           byte_item,
	output logic                           sym_valid,
	input  logic                           sym_ready,
	output hcte_pkg::sym_item_t            sym_item
);
	import hcte_pkg::*;

	logic      push_valid, push_ready;
	pair_job_t push_job;
	logic      pop_valid, pop_ready;
	pair_job_t pop_job;

	hcte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	hcte_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	hcte_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym_item  (sym_item)
	);

endmodule

FILE: bench/hcte_checker.sv
// Checker for the mod-29 Hill encryptor: tracks key writes and bytes, predicts and compares symbols.
`timescale 1ns / 100ps

module hcte_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [hcte_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcte_pkg::KEY_W-1:0]     cfg_data,
	input  logic                           byte_valid,
	input  logic                           byte_ready,
	input  hcte_pkg::byte_item_t           byte_item,
	input  logic                           sym_valid,
	input  logic                           sym_ready,
	input  hcte_pkg::sym_item_t            sym_item,
	output int                             fail_count,
	output int                             outstanding,
	output int                             symbols_seen
);

	import hcte_pkg::*;

	logic [KEY_W-1:0] key_q [4];
	logic             lead_q;
	logic             held_q;
	logic [SYM_W-1:0] held_sym_q;
	logic [ACC_W-1:0] held_acc_q;
	sym_item_t        cipher_q [$];
	int               mismatches = 0;
	int               received = 0;

	assign fail_count   = mismatches;
	assign symbols_seen = received;

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns  mismatch: %s", $time, what);
	endtask

	function automatic logic [SYM_W-1:0] plain_symbol(input logic [7:0] b);
		if (b == 8'h20 || b == 8'h23)
			return PAD_SYMBOL;
		if (b == 8'h2E)
			return 5'd27;
		if (b == 8'h2C)
			return 5'd28;
		if (b >= 8'h41 && b <= 8'h5A)
			return SYM_W'(b - 8'h40);
		if (b >= 8'h61 && b <= 8'h7A)
			return SYM_W'(b - 8'h60);
		return '0;
	endfunction

	// continuation byte after the lead; bit 5 does not matter
	function automatic sym_acc_t accent_letter(input logic [7:0] b);
		sym_acc_t r;
		r = '0;
		if (b[7:6] == 2'b10) begin
			case (b[4:0])
				5'h00: r = '{sym: 5'd1,  acc: ACC_GRAVE};
				5'h01: r = '{sym: 5'd1,  acc: ACC_ACUTE};
				5'h02: r = '{sym: 5'd1,  acc: ACC_CIRCUMFLEX};
				5'h03: r = '{sym: 5'd1,  acc: ACC_TILDE};
				5'h07: r = '{sym: 5'd3,  acc: ACC_CEDILLA};
				5'h08: r = '{sym: 5'd5,  acc: ACC_GRAVE};
				5'h09: r = '{sym: 5'd5,  acc: ACC_ACUTE};
				5'h0A: r = '{sym: 5'd5,  acc: ACC_CIRCUMFLEX};
				5'h0C: r = '{sym: 5'd9,  acc: ACC_GRAVE};
				5'h0D: r = '{sym: 5'd9,  acc: ACC_ACUTE};
				5'h0E: r = '{sym: 5'd9,  acc: ACC_CIRCUMFLEX};
				5'h12: r = '{sym: 5'd15, acc: ACC_GRAVE};
				5'h13: r = '{sym: 5'd15, acc: ACC_ACUTE};
				5'h14: r = '{sym: 5'd15, acc: ACC_CIRCUMFLEX};
				5'h15: r = '{sym: 5'd15, acc: ACC_TILDE};
				5'h19: r = '{sym: 5'd21, acc: ACC_GRAVE};
				5'h1A: r = '{sym: 5'd21, acc: ACC_ACUTE};
				5'h1B: r = '{sym: 5'd21, acc: ACC_CIRCUMFLEX};
				default: r = '0;
			endcase
		end
		return r;
	endfunction

	function automatic logic [SYM_W-1:0] key_row(input logic [KEY_W-1:0] ka,
			input logic [KEY_W-1:0] kb, input logic [SYM_W-1:0] s0,
			input logic [SYM_W-1:0] s1);
		int unsigned a, b, x, y;
		a = ka;
		b = kb;
		x = s0 - 1;
		y = s1 - 1;
		return SYM_W'((a * x + b * y) % MODULUS + 1);
	endfunction

	task automatic queue_pair(input logic [SYM_W-1:0] s0, input logic [ACC_W-1:0] a0,
			input logic [SYM_W-1:0] s1, input logic [ACC_W-1:0] a1, input logic eot);
		sym_item_t c;
		c.cipher_symbol = key_row(key_q[0], key_q[1], s0, s1);
		c.accent        = a0;
		c.last_in_run   = 1'b0;
		c.end_of_text   = eot;
		cipher_q.push_back(c);
		c.cipher_symbol = key_row(key_q[2], key_q[3], s0, s1);
		c.accent        = a1;
		c.last_in_run   = 1'b1;
		cipher_q.push_back(c);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sym_item_t        want;
		sym_acc_t         sa;
		logic [SYM_W-1:0] sym;
		logic [ACC_W-1:0] acc;
		string            diff;
		if (!arst_n) begin
			key_q[0]   = KEY_R0C0_RST;
			key_q[1]   = KEY_R0C1_RST;
			key_q[2]   = KEY_R1C0_RST;
			key_q[3]   = KEY_R1C1_RST;
			lead_q     = 1'b0;
			held_q     = 1'b0;
			held_sym_q = '0;
			held_acc_q = ACC_NONE;
			cipher_q.delete();
			outstanding <= 0;
		end else begin
			if (sym_valid && sym_ready) begin
				received++;
				if (cipher_q.size() == 0) begin
					report_mismatch($sformatf("unexpected symbol %0d accent %0d last %0b eot %0b",
						sym_item.cipher_symbol, sym_item.accent, sym_item.last_in_run,
						sym_item.end_of_text));
				end else begin
					want = cipher_q.pop_front();
					diff = "";
					if (sym_item.cipher_symbol !== want.cipher_symbol)
						diff = {diff, $sformatf(" symbol %0d/%0d", sym_item.cipher_symbol,
							want.cipher_symbol)};
					if (sym_item.accent !== want.accent)
						diff = {diff, $sformatf(" accent %0d/%0d", sym_item.accent, want.accent)};
					if (sym_item.last_in_run !== want.last_in_run)
						diff = {diff, $sformatf(" last %0b/%0b", sym_item.last_in_run,
							want.last_in_run)};
					if (sym_item.end_of_text !== want.end_of_text)
						diff = {diff, $sformatf(" eot %0b/%0b", sym_item.end_of_text,
							want.end_of_text)};
					if (diff != "")
						report_mismatch({"symbol", $sformatf(" #%0d (got/exp):", received), diff});
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					KEY_R0C0: key_q[0] = cfg_data;
					KEY_R0C1: key_q[1] = cfg_data;
					KEY_R1C0: key_q[2] = cfg_data;
					KEY_R1C1: key_q[3] = cfg_data;
					default: ;
				endcase
			end

			if (byte_valid && byte_ready) begin
				sym = '0;
				acc = ACC_NONE;
				if (byte_item.kind == KIND_END) begin
					if (held_q)
						queue_pair(held_sym_q, held_acc_q, PAD_SYMBOL, ACC_NONE, 1'b1);
					lead_q = 1'b0;
					held_q = 1'b0;
				end else if (lead_q) begin
					lead_q = 1'b0;
					sa     = accent_letter(byte_item.byte_value);
					sym    = sa.sym;
					acc    = sa.acc;
				end else if (byte_item.byte_value <= ASCII_MAX) begin
					sym = plain_symbol(byte_item.byte_value);
				end else if (byte_item.byte_value == LEAD_BYTE) begin
					lead_q = 1'b1;
				end

				if (sym != '0) begin
					if (!held_q) begin
						held_q     = 1'b1;
						held_sym_q = sym;
						held_acc_q = acc;
					end else begin
						queue_pair(held_sym_q, held_acc_q, sym, acc, 1'b0);
						held_q = 1'b0;
					end
				end
			end

			outstanding <= cipher_q.size();
		end
	end

endmodule

FILE: bench/testbench.sv
// Top of the mod-29 Hill encryptor bench: clock, reset, key and byte stimulus, verdict.
`timescale 1ns / 100ps

module testbench;

	import hcte_pkg::*;

	localparam int LIMIT = 600000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KEY_W-1:0]     cfg_data;
	logic                 byte_valid;
	logic                 byte_ready;
	byte_item_t           byte_item;
	logic                 sym_valid;
	logic                 sym_ready;
	sym_item_t            sym_item;

	int fail_count;
	int outstanding;
	int symbols_seen;
	int cycles = 0;
	int text_bytes = 0;
	int end_marks = 0;
	int key_sets = 0;
	bit calm = 1'b0;

	logic [4:0] accent_codes [18] = '{5'h00, 5'h01, 5'h02, 5'h03, 5'h07, 5'h08, 5'h09, 5'h0A,
		5'h0C, 5'h0D, 5'h0E, 5'h12, 5'h13, 5'h14, 5'h15, 5'h19, 5'h1A, 5'h1B};
	logic [7:0] punct [4] = '{8'h20, 8'h23, 8'h2E, 8'h2C};

	hill_cipher_mod29_text_encrypt_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.sym_item   (sym_item)
	);

	hcte_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.sym_valid    (sym_valid),
		.sym_ready    (sym_ready),
		.sym_item     (sym_item),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.symbols_seen (symbols_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d symbols still owed", cycles, outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	// output side back-pressure
	initial begin
		sym_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				sym_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			sym_ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic kind, input logic [7:0] value);
		byte_item_t it;
		it.kind       = kind;
		it.byte_value = value;
		if (!calm && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= it;
		do @(posedge clk); while (!byte_ready);
		if (kind == KIND_END)
			end_marks++;
		else
			text_bytes++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_keys(input logic [KEY_W-1:0] k00, input logic [KEY_W-1:0] k01,
			input logic [KEY_W-1:0] k10, input logic [KEY_W-1:0] k11);
		// unused index first, then the four key entries
		write_reg(CFG_IDX_W'($urandom_range(4, 15)), KEY_W'($urandom_range(0, 31)));
		write_reg(KEY_R0C0, k00);
		write_reg(KEY_R0C1, k01);
		write_reg(KEY_R1C0, k10);
		write_reg(KEY_R1C1, k11);
		cfg_valid <= 1'b0;
		@(posedge clk);
		key_sets++;
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// mostly real text with accents, some noise and broken lead bytes
	task automatic random_text(input int target);
		int kept;
		int r;
		kept = 0;
		while (kept < target) begin
			r = $urandom_range(0, 99);
			if (r < 38) begin
				send_byte(KIND_TEXT, 8'($urandom_range(0, 25)) +
					($urandom_range(0, 1) ? 8'h41 : 8'h61));
				kept++;
			end else if (r < 48) begin
				send_byte(KIND_TEXT, punct[$urandom_range(0, 3)]);
				kept++;
			end else if (r < 68) begin
				send_byte(KIND_TEXT, LEAD_BYTE);
				send_byte(KIND_TEXT, 8'h80 | (8'($urandom_range(0, 1)) << 5) |
					8'(accent_codes[$urandom_range(0, 17)]));
				kept++;
			end else if (r < 83) begin
				send_byte(KIND_TEXT, 8'($urandom_range(0, 255)));
			end else if (r < 90) begin
				send_byte(KIND_TEXT, LEAD_BYTE);
				send_byte(KIND_TEXT, 8'($urandom_range(0, 255)));
			end else if (r < 96) begin
				send_byte(KIND_END, 8'($urandom_range(0, 255)));
				kept++;
			end else begin
				send_byte(KIND_TEXT, LEAD_BYTE);
				send_byte(KIND_END, 8'($urandom_range(0, 255)));
				kept++;
			end
		end
		send_byte(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		byte_valid = 1'b0;
		byte_item  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed text under the reset key
		send_byte(KIND_TEXT, 8'h61);
		send_byte(KIND_TEXT, 8'h5A);
		send_byte(KIND_TEXT, 8'h20);
		send_byte(KIND_TEXT, 8'h23);
		send_byte(KIND_TEXT, 8'h00);
		send_byte(KIND_TEXT, 8'hFF);
		send_byte(KIND_TEXT, 8'h7F);
		send_byte(KIND_TEXT, 8'h2E);
		send_byte(KIND_TEXT, 8'h2C);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, 8'hA9);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, 8'h87);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, 8'h41);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_TEXT, 8'hA3);
		send_byte(KIND_END, 8'hFF);
		send_byte(KIND_END, 8'h00);
		send_byte(KIND_TEXT, LEAD_BYTE);
		send_byte(KIND_END, 8'h55);
		send_byte(KIND_TEXT, 8'h6D);
		send_byte(KIND_END, 8'hAA);
		settle();

		load_keys(5'd0, 5'd0, 5'd0, 5'd0);
		random_text(50);
		settle();
		load_keys(5'd31, 5'd31, 5'd31, 5'd31);
		random_text(50);
		settle();
		load_keys(5'd28, 5'd28, 5'd28, 5'd28);
		random_text(50);
		settle();
		load_keys(KEY_W'($urandom_range(0, 31)), KEY_W'($urandom_range(0, 31)),
			KEY_W'($urandom_range(0, 31)), KEY_W'($urandom_range(0, 31)));
		random_text(50);
		settle();
		calm = 1'b1;
		load_keys(KEY_W'($urandom_range(0, 31)), KEY_W'($urandom_range(0, 31)),
			KEY_W'($urandom_range(0, 31)), KEY_W'($urandom_range(0, 31)));
		random_text(50);
		settle();

		$display("sent %0d text bytes and %0d end markers under %0d key loads plus reset key",
			text_bytes, end_marks, key_sets);
		$display("compared %0d cipher symbols, %0d mismatches", symbols_seen, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
